// ===== rtl/rsc_pkg.sv =====
// Shared types, constants and helpers for the Rabbit stream cipher block.
`default_nettype none
package rsc_pkg;

	localparam int unsigned NUM_WORDS = 8;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned BLOCK_W = 128;
	localparam int unsigned REG_W = 64;

	// step counter: 0..7 counter/sum per word, 1..8 squaring, 9 state combine
	localparam logic [3:0] STEP_LAST = 4'd9;
	localparam logic [1:0] SETUP_LAST = 2'd3;

	localparam logic [31:0] CTR_A = 32'h4d34d34d;
	localparam logic [31:0] CTR_B = 32'hd34d34d3;
	localparam logic [31:0] CTR_C = 32'h34d34d34;
	localparam logic [31:0] IV_HI_MASK = 32'hffff0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY,
		ST_ITER,
		ST_FIX,
		ST_OUT
	} fsm_t;

	typedef enum logic [1:0] {
		PH_KEY,
		PH_IV,
		PH_RUN
	} phase_t;

	typedef enum logic [1:0] {
		REG_KEY_LOW,
		REG_KEY_HIGH,
		REG_IV_VALUE,
		REG_IV_ENABLE
	} cfg_reg_t;

	typedef struct packed {
		logic load_key;
		logic fix_ctr;
		logic run;
		logic load_out;
	} ctl_t;

	function automatic logic [31:0] ctr_const(input logic [2:0] idx);
		logic [31:0] c;
		unique case (idx)
			3'd0, 3'd3, 3'd6: c = CTR_A;
			3'd1, 3'd4, 3'd7: c = CTR_B;
			default:          c = CTR_C;
		endcase
		return c;
	endfunction

	function automatic logic [31:0] rotl16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

	function automatic logic [31:0] rotl8(input logic [31:0] v);
		return {v[23:0], v[31:24]};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/rsc_gsq.sv =====
// Rabbit g-function: 32-bit square folded as high half XOR low half.
`default_nettype none
module rsc_gsq (
	input  wire logic [rsc_pkg::WORD_W-1:0] sum,
	output logic      [rsc_pkg::WORD_W-1:0] g
);
	import rsc_pkg::*;

	logic [2*WORD_W-1:0] sq;

	assign sq = {{WORD_W{1'b0}}, sum} * {{WORD_W{1'b0}}, sum};
	assign g = sq[2*WORD_W-1:WORD_W] ^ sq[WORD_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/rabbit_stream_cipher.sv =====
// Rabbit stream cipher: 16-byte words, key/IV setup on restart, one shared squarer.
// Each cipher iteration runs the 8 words through the single squarer, then combines the state.
// Plain word: the next word is taken only after the result register frees up, so each word
// is finished before the next one is accepted.
// Restart adds key setup, plus IV setup when enabled.
// Async active-low reset clears state, counters, carry, configuration registers and control.
`default_nettype none
module rabbit_stream_cipher (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,   // data_low [63:0], data_high [127:64]
	input  wire logic         s_tuser,   // restart
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [127:0] m_tdata,   // out_low [63:0], out_high [127:64]
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [63:0]  cfg_data
);
	import rsc_pkg::*;

	fsm_t   fsm_q, fsm_d;
	phase_t phase_q;
	ctl_t   ctl;

	logic [3:0]  step_q;
	logic [1:0]  iter_q;
	logic [31:0] x_q [NUM_WORDS];
	logic [31:0] c_q [NUM_WORDS];
	logic [31:0] g_q [NUM_WORDS];
	logic        carry_q;
	logic [31:0] sum_s1;
	logic [BLOCK_W-1:0] data_q;
	logic [BLOCK_W-1:0] out_q;
	logic        out_valid_q;

	logic [REG_W-1:0] key_low_q, key_high_q, iv_q;
	logic             iv_en_q;

	logic [2:0]  widx, gidx;
	logic        add_step, sq_step, last_step;
	logic [32:0] ctr_sum;
	logic [31:0] g_w;
	logic [31:0] x_new   [NUM_WORDS];
	logic [31:0] x_key   [NUM_WORDS];
	logic [31:0] c_key   [NUM_WORDS];
	logic [31:0] iv_mix  [NUM_WORDS];
	logic [15:0] kw      [NUM_WORDS];
	logic [31:0] s0, s1, s2, s3;
	logic        accept;

	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;

	// ---- configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			iv_q       <= '0;
			iv_en_q    <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KEY_LOW:   key_low_q  <= cfg_data;
				REG_KEY_HIGH:  key_high_q <= cfg_data;
				REG_IV_VALUE:  iv_q       <= cfg_data;
				REG_IV_ENABLE: iv_en_q    <= cfg_data[0];
			endcase
		end
	end

	// ---- sequencer
	always_comb begin
		fsm_d = fsm_q;
		unique case (fsm_q)
			ST_IDLE: if (s_tvalid) begin
				fsm_d = s_tuser ? ST_KEY : ST_ITER;
			end
			ST_KEY: fsm_d = ST_ITER;
			ST_ITER: if (last_step) begin
				if (phase_q == PH_KEY && iter_q == SETUP_LAST) fsm_d = ST_FIX;
				else if (phase_q == PH_RUN) fsm_d = ST_OUT;
			end
			ST_FIX: fsm_d = ST_ITER;
			ST_OUT: if (!out_valid_q || m_tready) begin
				fsm_d = ST_IDLE;
			end
			default: fsm_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = (fsm_q == ST_IDLE);
		ctl.load_key = (fsm_q == ST_KEY);
		ctl.fix_ctr  = (fsm_q == ST_FIX);
		ctl.run      = (fsm_q == ST_ITER);
		ctl.load_out = (fsm_q == ST_OUT) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= ST_IDLE;
			phase_q <= PH_RUN;
			step_q  <= '0;
			iter_q  <= '0;
		end else begin
			fsm_q <= fsm_d;
			if (accept) begin
				phase_q <= s_tuser ? PH_KEY : PH_RUN;
				step_q  <= '0;
				iter_q  <= '0;
			end else if (ctl.fix_ctr) begin
				phase_q <= iv_en_q ? PH_IV : PH_RUN;
				step_q  <= '0;
				iter_q  <= '0;
			end else if (ctl.run) begin
				if (last_step) begin
					step_q <= '0;
					iter_q <= iter_q + 2'd1;
					if (phase_q == PH_IV && iter_q == SETUP_LAST) begin
						phase_q <= PH_RUN;
					end
				end else begin
					step_q <= step_q + 4'd1;
				end
			end
		end
	end

	// ---- shared iteration datapath
	assign widx      = step_q[2:0];
	assign gidx      = step_q[2:0] - 3'd1;
	assign add_step  = ctl.run && !step_q[3];
	assign sq_step   = ctl.run && (step_q != 4'd0) && (step_q <= 4'd8);
	assign last_step = (step_q == STEP_LAST);

	assign ctr_sum = {1'b0, c_q[widx]} + {1'b0, ctr_const(widx)} + {32'd0, carry_q};

	rsc_gsq u_gsq (
		.sum (sum_s1),
		.g   (g_w)
	);

	always_comb begin
		for (int i = 0; i < NUM_WORDS; i += 2) begin
			x_new[i] = g_q[i] + rotl16(g_q[(i + 7) % NUM_WORDS])
				+ rotl16(g_q[(i + 6) % NUM_WORDS]);
			x_new[i + 1] = g_q[i + 1] + rotl8(g_q[i]) + g_q[(i + 7) % NUM_WORDS];
		end
	end

	// key expansion from the eight 16-bit key words
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			kw[j]     = key_low_q[16*j +: 16];
			kw[j + 4] = key_high_q[16*j +: 16];
		end
		for (int i = 0; i < NUM_WORDS; i += 2) begin
			x_key[i]     = {kw[(i + 1) % NUM_WORDS], kw[i]};
			c_key[i]     = {kw[(i + 4) % NUM_WORDS], kw[(i + 5) % NUM_WORDS]};
			x_key[i + 1] = {kw[(i + 6) % NUM_WORDS], kw[(i + 5) % NUM_WORDS]};
			c_key[i + 1] = {kw[(i + 1) % NUM_WORDS], kw[(i + 2) % NUM_WORDS]};
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_WORDS; i += 4) begin
			iv_mix[i]     = iv_q[31:0];
			iv_mix[i + 1] = (iv_q[63:32] & IV_HI_MASK) | {16'd0, iv_q[31:16]};
			iv_mix[i + 2] = iv_q[63:32];
			iv_mix[i + 3] = {iv_q[47:32], iv_q[15:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				x_q[i] <= '0;
				c_q[i] <= '0;
			end
			carry_q <= 1'b0;
		end else if (ctl.load_key) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				x_q[i] <= x_key[i];
				c_q[i] <= c_key[i];
			end
			carry_q <= 1'b0;
		end else if (ctl.fix_ctr) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				c_q[i] <= c_q[i] ^ x_q[(i + 4) % NUM_WORDS] ^ (iv_en_q ? iv_mix[i] : 32'd0);
			end
		end else if (ctl.run) begin
			if (add_step) begin
				c_q[widx] <= ctr_sum[31:0];
				carry_q   <= ctr_sum[32];
			end
			if (last_step) begin
				for (int i = 0; i < NUM_WORDS; i++) begin
					x_q[i] <= x_new[i];
				end
			end
		end
	end

	// sum and g words need no reset
	always_ff @(posedge clk) begin
		if (add_step) begin
			sum_s1 <= x_q[widx] + ctr_sum[31:0];
		end
		if (sq_step) begin
			g_q[gidx] <= g_w;
		end
		if (accept) begin
			data_q <= s_tdata;
		end
	end

	// ---- keystream extraction and output register
	assign s0 = x_q[0] ^ {16'd0, x_q[5][31:16]} ^ {x_q[3][15:0], 16'd0};
	assign s1 = x_q[2] ^ {16'd0, x_q[7][31:16]} ^ {x_q[5][15:0], 16'd0};
	assign s2 = x_q[4] ^ {16'd0, x_q[1][31:16]} ^ {x_q[7][15:0], 16'd0};
	assign s3 = x_q[6] ^ {16'd0, x_q[3][31:16]} ^ {x_q[1][15:0], 16'd0};

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			out_q <= data_q ^ {s3, s2, s1, s0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/rsc_checker.sv =====
// Port-level checks for the Rabbit stream cipher, bound to the top level.
`default_nettype none
module rsc_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tvalid,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [127:0] m_tdata,
	input wire logic         cfg_valid,
	input wire logic         cfg_ready
);

	// a word in flight drops input ready right after it is taken
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after accept");

	// no result can appear in the cycle after a word is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output word changed");

	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind rabbit_stream_cipher rsc_checker u_rsc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for rabbit_stream_cipher: cipher predictor, random traffic and stalls.
module testbench;
	import rsc_pkg::*;

	localparam int LONG_HOLD = 300;
	localparam int TAIL_CYCLES = 30;
	localparam int PRINT_CAP = 50;

	typedef enum int {
		RX_ALWAYS,
		RX_PATTERN,
		RX_RANDOM
	} rx_mode_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index = '0;
	logic [63:0]  cfg_data = '0;

	rabbit_stream_cipher u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state and register copies
	logic [31:0] ks_x [8];
	logic [31:0] ks_c [8];
	logic        ks_carry;
	logic [63:0] p_key_lo;
	logic [63:0] p_key_hi;
	logic [63:0] p_iv;
	logic        p_iv_en;

	logic [127:0] expected_blocks [$];
	logic [127:0] want_block;
	int           errors = 0;

	// sender and receiver control
	bit       gaps_on = 1'b1;
	int       burst_left = 0;
	rx_mode_t rx_mode = RX_RANDOM;
	int       rx_period = 4;
	int       rx_busy = 1;
	int       rx_cycle = 0;
	bit       hold_req = 1'b0;
	int       hold_left = 0;

	function automatic logic [31:0] rotl_word(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] g_mix(input logic [31:0] u);
		logic [63:0] sq;
		sq = {32'd0, u} * {32'd0, u};
		return sq[63:32] ^ sq[31:0];
	endfunction

	function automatic logic [31:0] ctr_step_const(input int i);
		case (i % 3)
			0: return CTR_A;
			1: return CTR_B;
			default: return CTR_C;
		endcase
	endfunction

	function automatic void cipher_round();
		logic [31:0] gv [8];
		logic [32:0] t;
		for (int i = 0; i < 8; i++) begin
			t = {1'b0, ks_c[i]} + {1'b0, ctr_step_const(i)} + {32'd0, ks_carry};
			ks_carry = t[32];
			ks_c[i] = t[31:0];
			gv[i] = g_mix(ks_x[i] + ks_c[i]);
		end
		for (int j = 0; j < 8; j++) begin
			if (j % 2 == 0)
				ks_x[j] = gv[j] + rotl_word(gv[(j + 7) % 8], 16) + rotl_word(gv[(j + 6) % 8], 16);
			else
				ks_x[j] = gv[j] + rotl_word(gv[(j + 7) % 8], 8) + gv[(j + 6) % 8];
		end
	endfunction

	function automatic void key_load();
		logic [15:0] k [8];
		for (int i = 0; i < 4; i++) begin
			k[i] = p_key_lo[16 * i +: 16];
			k[i + 4] = p_key_hi[16 * i +: 16];
		end
		for (int i = 0; i < 8; i += 2) begin
			ks_x[i] = {k[(i + 1) % 8], k[i]};
			ks_c[i] = {k[(i + 4) % 8], k[(i + 5) % 8]};
			ks_x[i + 1] = {k[(i + 6) % 8], k[(i + 5) % 8]};
			ks_c[i + 1] = {k[(i + 1) % 8], k[(i + 2) % 8]};
		end
		ks_carry = 1'b0;
		for (int r = 0; r < 4; r++)
			cipher_round();
		for (int i = 0; i < 8; i++)
			ks_c[i] ^= ks_x[(i + 4) % 8];
	endfunction

	function automatic void iv_load();
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] m1;
		logic [31:0] m3;
		lo = p_iv[31:0];
		hi = p_iv[63:32];
		m1 = (hi & IV_HI_MASK) | (lo >> 16);
		m3 = (hi << 16) | {16'd0, lo[15:0]};
		for (int i = 0; i < 8; i += 4) begin
			ks_c[i] ^= lo;
			ks_c[i + 1] ^= m1;
			ks_c[i + 2] ^= hi;
			ks_c[i + 3] ^= m3;
		end
		// carry from key setup is carried on here
		for (int r = 0; r < 4; r++)
			cipher_round();
	endfunction

	function automatic logic [127:0] predict_block(input logic restart, input logic [127:0] data);
		logic [31:0] s0, s1, s2, s3;
		if (restart) begin
			key_load();
			if (p_iv_en)
				iv_load();
		end
		cipher_round();
		s0 = ks_x[0] ^ (ks_x[5] >> 16) ^ (ks_x[3] << 16);
		s1 = ks_x[2] ^ (ks_x[7] >> 16) ^ (ks_x[5] << 16);
		s2 = ks_x[4] ^ (ks_x[1] >> 16) ^ (ks_x[7] << 16);
		s3 = ks_x[6] ^ (ks_x[3] >> 16) ^ (ks_x[1] << 16);
		return data ^ {s3, s2, s1, s0};
	endfunction

	function automatic logic [127:0] rand_block();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_reg();
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < PRINT_CAP)
			$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_blocks.size() == 0) begin
				report_mismatch("result word with nothing pending");
			end else begin
				want_block = expected_blocks.pop_front();
				if (m_tdata[63:0] !== want_block[63:0])
					report_mismatch($sformatf("out_low %h, want %h",
						m_tdata[63:0], want_block[63:0]));
				if (m_tdata[127:64] !== want_block[127:64])
					report_mismatch($sformatf("out_high %h, want %h",
						m_tdata[127:64], want_block[127:64]));
			end
		end
	end

	// receiver: long hold-off on request, otherwise the current stall pattern
	always @(negedge clk) begin
		rx_cycle++;
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_PATTERN: m_tready <= ((rx_cycle % rx_period) >= rx_busy);
				default: m_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	task automatic send_block(input logic restart, input logic [127:0] data);
		int gap;
		gap = 0;
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 12);
			end
			burst_left--;
		end
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= restart;
		s_tdata <= data;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		expected_blocks.push_back(predict_block(restart, data));
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_blocks.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [63:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		case (idx)
			REG_KEY_LOW: p_key_lo = value;
			REG_KEY_HIGH: p_key_hi = value;
			REG_IV_VALUE: p_iv = value;
			REG_IV_ENABLE: p_iv_en = value[0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_rx_pattern(input rx_mode_t mode);
		rx_mode = mode;
		rx_period = $urandom_range(2, 9);
		rx_busy = $urandom_range(1, rx_period - 1);
	endtask

	// keystream straight from the all-zero reset state
	task automatic test_zero_state();
		set_rx_pattern(RX_RANDOM);
		send_block(1'b0, '0);
		send_block(1'b0, '1);
		send_block(1'b0, {64{2'b01}});
		drain_results();
	endtask

	task automatic test_key_extremes();
		cfg_write(REG_KEY_LOW, '0);
		cfg_write(REG_KEY_HIGH, '0);
		cfg_write(REG_IV_ENABLE, 64'hffff_ffff_ffff_fffe);
		send_block(1'b1, '0);
		send_block(1'b0, '1);
		drain_results();
		cfg_write(REG_KEY_LOW, '1);
		cfg_write(REG_KEY_HIGH, '1);
		send_block(1'b1, rand_block());
		send_block(1'b0, rand_block());
		drain_results();
		cfg_write(REG_IV_VALUE, '1);
		cfg_write(REG_IV_ENABLE, 64'd1);
		send_block(1'b1, '1);
		send_block(1'b0, '0);
		drain_results();
		cfg_write(REG_IV_VALUE, '0);
		send_block(1'b1, rand_block());
		drain_results();
	endtask

	// new key and IV must not disturb the running stream until restart
	task automatic test_midstream_write();
		set_rx_pattern(RX_PATTERN);
		cfg_write(REG_KEY_LOW, rand_reg());
		cfg_write(REG_KEY_HIGH, rand_reg());
		cfg_write(REG_IV_VALUE, rand_reg());
		cfg_write(REG_IV_ENABLE, 64'd1);
		send_block(1'b1, rand_block());
		send_block(1'b0, rand_block());
		send_block(1'b0, rand_block());
		drain_results();
		cfg_write(REG_KEY_LOW, rand_reg());
		cfg_write(REG_KEY_HIGH, rand_reg());
		cfg_write(REG_IV_VALUE, rand_reg());
		send_block(1'b0, rand_block());
		send_block(1'b0, rand_block());
		send_block(1'b1, rand_block());
		drain_results();
	endtask

	// output held off long enough for the input side to back up
	task automatic test_output_backpressure();
		set_rx_pattern(RX_RANDOM);
		gaps_on = 1'b0;
		hold_req = 1'b1;
		send_block(1'b1, rand_block());
		for (int i = 0; i < 15; i++)
			send_block(1'b0, rand_block());
		drain_results();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic restart;
		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: begin
					cfg_write(REG_KEY_LOW, '0);
					cfg_write(REG_KEY_HIGH, '0);
					cfg_write(REG_IV_VALUE, '0);
					cfg_write(REG_IV_ENABLE, '0);
				end
				1: begin
					cfg_write(REG_KEY_LOW, '1);
					cfg_write(REG_KEY_HIGH, '1);
					cfg_write(REG_IV_VALUE, '1);
					cfg_write(REG_IV_ENABLE, '1);
				end
				default: begin
					cfg_write(REG_IV_ENABLE, rand_reg());
					cfg_write(REG_IV_VALUE, rand_reg());
					cfg_write(REG_KEY_HIGH, rand_reg());
					cfg_write(REG_KEY_LOW, rand_reg());
				end
			endcase
			set_rx_pattern(rx_mode_t'(phase % 3));
			gaps_on = (phase != 3);
			for (int i = 0; i < 100; i++) begin
				// most phases open with a restart; some carry the old stream on
				if (i == 0)
					restart = ($urandom_range(0, 3) != 0);
				else
					restart = ($urandom_range(0, 15) == 0);
				send_block(restart, rand_block());
			end
			drain_results();
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < 8; i++) begin
			ks_x[i] = '0;
			ks_c[i] = '0;
		end
		ks_carry = 1'b0;
		p_key_lo = '0;
		p_key_hi = '0;
		p_iv = '0;
		p_iv_en = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		test_zero_state();
		test_key_extremes();
		test_midstream_write();
		test_output_backpressure();
		test_random_traffic();

		if (errors == 0)
			$display("rabbit_stream_cipher test passed");
		else
			$display("rabbit_stream_cipher test failed");
		$finish;
	end

	initial begin
		#6000000;
		$display("rabbit_stream_cipher test failed");
		$finish;
	end

endmodule
